// ----- design/isotp_transport_engine_assert.svh -----
// Assertion macros for the checker file of the ISO-TP engine
`ifndef ISOTP_TRANSPORT_ENGINE_ASSERT_SVH
`define ISOTP_TRANSPORT_ENGINE_ASSERT_SVH

// checked only while out of reset
`define ISOTP_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: %s failed", "name");

// checked at every edge, reset included
`define ISOTP_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: %s failed", "name");

`endif

// ----- design/isotp_pkg.sv -----
// Types, codes and constants of the ISO-TP transport engine
package isotp_pkg;

  localparam int unsigned AddrW = 12;
  localparam logic [AddrW-1:0] MAX_PDU = 12'd4095;

  localparam logic [7:0] SEQ_FIRST = 8'h21;
  localparam logic [7:0] SEQ_LAST = 8'h2F;
  localparam logic [7:0] SEQ_WRAP = 8'h20;
  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;
  localparam logic [3:0] PCI_FC = 4'h3;
  localparam logic [7:0] FF_MARK = 8'h10;
  localparam logic [7:0] ST_MS_MAX = 8'h7F;
  localparam logic [7:0] ST_US_MIN = 8'hF1;
  localparam logic [7:0] ST_US_MAX = 8'hF9;
  localparam logic [16:0] SEP_DEFAULT = 17'd127000;
  localparam logic [3:0] FC_CTS = 4'h0;
  localparam logic [3:0] FC_WAIT = 4'h1;
  localparam logic [31:0] FLOW_TIMEOUT_RST = 32'd1000000;

  typedef enum logic [2:0] {
    OP_RX    = 3'd0,
    OP_LOAD  = 3'd1,
    OP_START = 3'd2,
    OP_POLL  = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_NONE   = 4'd0,
    ST_ERROR  = 4'd1,
    ST_DONE   = 4'd2,
    ST_NEEDFC = 4'd3,
    ST_CONT   = 4'd4,
    ST_WAIT   = 4'd5,
    ST_ABORT  = 4'd6,
    ST_CLEAR  = 4'd7,
    ST_REJECT = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_SEND = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RX_WR,
    S_TX_RD,
    S_POLL_ADD,
    S_TMO,
    S_RD_WAIT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [15:0]      can_id;
    logic [3:0]       frame_dlc;
    logic [63:0]      frame_data;
    logic [63:0]      now_us;
    logic [AddrW-1:0] pdu_length;
    logic [AddrW-1:0] buffer_index;
    logic [7:0]       tx_byte;
  } item_t;

  typedef struct packed {
    status_e          status;
    logic             frame_valid;
    logic [15:0]      out_id;
    logic [3:0]       out_dlc;
    logic [63:0]      out_data;
    logic             timed_out;
    logic [AddrW-1:0] received_length;
    logic [7:0]       read_byte;
  } res_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [63:0] sum;
    logic        carry;
  } alu_rsp_t;

  function automatic logic [7:0] next_seq(input logic [7:0] s);
    return (s == SEQ_LAST) ? SEQ_WRAP : 8'(s + 8'd1);
  endfunction

endpackage

// ----- design/isotp_alu.sv -----
// Shared 64-bit add/subtract unit; carry set on subtract means a >= b
module isotp_alu (
  input  isotp_pkg::alu_req_t req_i,
  output isotp_pkg::alu_rsp_t rsp_o
);
  import isotp_pkg::*;

  logic [63:0] b_op;

  assign b_op = req_i.sub ? ~req_i.b : req_i.b;
  assign {rsp_o.carry, rsp_o.sum} = {1'b0, req_i.a} + {1'b0, b_op} + {64'd0, req_i.sub};

endmodule

// ----- design/isotp_engine.sv -----
// Sequencer, byte stores and protocol state of the ISO-TP engine
module isotp_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  isotp_pkg::item_t   item_i,
  input  logic [31:0]        flow_timeout_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output isotp_pkg::res_t    res_o
);
  import isotp_pkg::*;

  state_e state_q, state_d;

  logic [2:0]       op_q, op_d;
  logic [15:0]      id_q, id_d;
  logic [3:0]       dlc_q, dlc_d;
  logic [63:0]      data_q, data_d;
  logic [63:0]      now_q, now_d;
  logic [AddrW-1:0] plen_q, plen_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [7:0]       tbyte_q, tbyte_d;

  logic [AddrW-1:0] rx_exp_q, rx_exp_d;
  logic [AddrW-1:0] rx_cnt_q, rx_cnt_d;
  logic [7:0]       rx_seq_q, rx_seq_d;
  logic             rx_multi_q, rx_multi_d;

  logic [AddrW-1:0] tx_len_q, tx_len_d;
  logic [AddrW-1:0] tx_pos_q, tx_pos_d;
  logic [15:0]      tx_ident_q, tx_ident_d;
  logic [7:0]       tx_seq_q, tx_seq_d;
  logic [7:0]       tx_bs_q, tx_bs_d;
  logic [7:0]       tx_rem_q, tx_rem_d;
  logic [16:0]      tx_sep_q, tx_sep_d;
  phase_e           tx_phase_q, tx_phase_d;
  logic [63:0]      tx_next_q, tx_next_d;
  logic [63:0]      tx_wait_q, tx_wait_d;
  logic [63:0]      tx_last_q, tx_last_d;

  logic [3:0]       cnt_q, cnt_d;
  logic [3:0]       n_q, n_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [2:0]       slot_q, slot_d;

  status_e          r_status_q, r_status_d;
  logic             r_valid_q, r_valid_d;
  logic [15:0]      r_id_q, r_id_d;
  logic [3:0]       r_dlc_q, r_dlc_d;
  logic [63:0]      r_data_q, r_data_d;
  logic             r_tmo_q, r_tmo_d;
  logic [7:0]       r_rbyte_q, r_rbyte_d;

  // byte stores
  logic [7:0]       rx_mem [MAX_PDU];
  logic [7:0]       tx_mem [MAX_PDU];
  logic             rx_we, tx_we;
  logic [AddrW-1:0] rx_waddr, rx_raddr, tx_waddr, tx_raddr;
  logic [7:0]       tx_wdata;
  logic [7:0]       rx_rdata_q, tx_rdata_q;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  isotp_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  logic [7:0]       pci;
  logic [7:0]       st_raw;
  logic [3:0]       cf_chunk0, cf_chunk, ff_chunk, tx_chunk;
  logic [AddrW-1:0] rx_room, rx_cnt_new, tx_left, loop_addr;
  logic [AddrW-1:0] ff_len;
  logic [16:0]      sep_calc;
  logic [2:0]       slot_sel;

  assign pci       = data_q[7:0];
  assign st_raw    = data_q[23:16];
  assign cf_chunk0 = 4'(dlc_q - 4'd1);
  assign ff_chunk  = 4'(dlc_q - 4'd2);
  assign rx_room   = rx_exp_q - rx_cnt_q;
  assign cf_chunk  = (rx_room < {8'd0, cf_chunk0}) ? rx_room[3:0] : cf_chunk0;
  assign rx_cnt_new = rx_cnt_q + {8'd0, cf_chunk};
  assign tx_left   = tx_len_q - tx_pos_q;
  assign tx_chunk  = (tx_left < 12'd7) ? tx_left[3:0] : 4'd7;
  assign ff_len    = {pci[3:0], data_q[15:8]};
  assign loop_addr = base_q + {8'd0, cnt_q};
  assign slot_sel  = 3'(slot_q + cnt_q[2:0] - 3'd1);

  always_comb begin
    if (st_raw <= ST_MS_MAX) begin
      sep_calc = 17'({10'd0, st_raw[6:0]} * 17'd1000);
    end else if (st_raw >= ST_US_MIN && st_raw <= ST_US_MAX) begin
      sep_calc = 17'({13'd0, st_raw[3:0]} * 17'd100);
    end else begin
      sep_calc = SEP_DEFAULT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_waddr] <= data_q[7:0];
    end
    rx_rdata_q <= rx_mem[rx_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_waddr] <= tx_wdata;
    end
    tx_rdata_q <= tx_mem[tx_raddr];
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    id_d       = id_q;
    dlc_d      = dlc_q;
    data_d     = data_q;
    now_d      = now_q;
    plen_d     = plen_q;
    idx_d      = idx_q;
    tbyte_d    = tbyte_q;
    rx_exp_d   = rx_exp_q;
    rx_cnt_d   = rx_cnt_q;
    rx_seq_d   = rx_seq_q;
    rx_multi_d = rx_multi_q;
    tx_len_d   = tx_len_q;
    tx_pos_d   = tx_pos_q;
    tx_ident_d = tx_ident_q;
    tx_seq_d   = tx_seq_q;
    tx_bs_d    = tx_bs_q;
    tx_rem_d   = tx_rem_q;
    tx_sep_d   = tx_sep_q;
    tx_phase_d = tx_phase_q;
    tx_next_d  = tx_next_q;
    tx_wait_d  = tx_wait_q;
    tx_last_d  = tx_last_q;
    cnt_d      = cnt_q;
    n_d        = n_q;
    base_d     = base_q;
    slot_d     = slot_q;
    r_status_d = r_status_q;
    r_valid_d  = r_valid_q;
    r_id_d     = r_id_q;
    r_dlc_d    = r_dlc_q;
    r_data_d   = r_data_q;
    r_tmo_d    = r_tmo_q;
    r_rbyte_d  = r_rbyte_q;

    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    rx_we       = 1'b0;
    tx_we       = 1'b0;
    rx_waddr    = loop_addr;
    rx_raddr    = idx_q;
    tx_waddr    = idx_q;
    tx_wdata    = tbyte_q;
    tx_raddr    = loop_addr;

    alu_req.a   = now_q;
    alu_req.b   = tx_next_q;
    alu_req.sub = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d       = item_i.opcode;
          id_d       = item_i.can_id;
          dlc_d      = (item_i.frame_dlc > 4'd8) ? 4'd8 : item_i.frame_dlc;
          data_d     = item_i.frame_data;
          now_d      = item_i.now_us;
          plen_d     = item_i.pdu_length;
          idx_d      = item_i.buffer_index;
          tbyte_d    = item_i.tx_byte;
          r_status_d = ST_NONE;
          r_valid_d  = 1'b0;
          r_id_d     = '0;
          r_dlc_d    = '0;
          r_data_d   = '0;
          r_tmo_d    = 1'b0;
          r_rbyte_d  = '0;
          cnt_d      = '0;
          state_d    = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_FINISH;
        cnt_d   = '0;
        unique case (op_q)
          OP_RX: begin
            if (dlc_q == 4'd0) begin
              r_status_d = ST_ERROR;
            end else if (pci[7:4] == PCI_SF && !pci[3]) begin
              if (pci[3:0] > cf_chunk0) begin
                rx_exp_d   = '0;
                rx_cnt_d   = '0;
                rx_seq_d   = SEQ_FIRST;
                rx_multi_d = 1'b0;
                r_status_d = ST_ERROR;
              end else begin
                rx_exp_d   = {8'd0, pci[3:0]};
                rx_cnt_d   = {8'd0, pci[3:0]};
                rx_multi_d = 1'b0;
                r_status_d = ST_DONE;
                data_d     = data_q >> 8;
                base_d     = '0;
                n_d        = pci[3:0];
                if (pci[3:0] != 4'd0) begin
                  state_d = S_RX_WR;
                end
              end
            end else if (pci[7:4] == PCI_FF) begin
              if (dlc_q < 4'd2 || ff_len <= 12'd7) begin
                rx_exp_d   = '0;
                rx_cnt_d   = '0;
                rx_seq_d   = SEQ_FIRST;
                rx_multi_d = 1'b0;
                r_status_d = ST_ERROR;
              end else begin
                rx_exp_d   = ff_len;
                rx_cnt_d   = {8'd0, ff_chunk};
                rx_seq_d   = SEQ_FIRST;
                rx_multi_d = 1'b1;
                r_status_d = ST_NEEDFC;
                data_d     = data_q >> 16;
                base_d     = '0;
                n_d        = ff_chunk;
                if (ff_chunk != 4'd0) begin
                  state_d = S_RX_WR;
                end
              end
            end else if (pci[7:4] == PCI_CF) begin
              if (!rx_multi_q) begin
                r_status_d = ST_ERROR;
              end else if (pci != rx_seq_q) begin
                rx_exp_d   = '0;
                rx_cnt_d   = '0;
                rx_seq_d   = SEQ_FIRST;
                rx_multi_d = 1'b0;
                r_status_d = ST_ERROR;
              end else begin
                rx_seq_d = next_seq(rx_seq_q);
                rx_cnt_d = rx_cnt_new;
                base_d   = rx_cnt_q;
                n_d      = cf_chunk;
                data_d   = data_q >> 8;
                if (rx_cnt_new >= rx_exp_q) begin
                  rx_multi_d = 1'b0;
                  r_status_d = ST_DONE;
                end else begin
                  r_status_d = ST_CONT;
                end
                if (cf_chunk != 4'd0) begin
                  state_d = S_RX_WR;
                end
              end
            end else if (pci[7:4] == PCI_FC) begin
              if (tx_phase_q == PH_IDLE) begin
                r_status_d = ST_CONT;
              end else if (pci[3:0] == FC_WAIT) begin
                tx_phase_d = PH_WAIT;
                tx_wait_d  = tx_last_q;
                r_status_d = ST_WAIT;
              end else if (pci[3:0] != FC_CTS || dlc_q < 4'd3) begin
                tx_phase_d = PH_IDLE;
                r_status_d = ST_ABORT;
              end else begin
                tx_bs_d    = data_q[15:8];
                tx_rem_d   = data_q[15:8];
                tx_sep_d   = sep_calc;
                tx_phase_d = PH_SEND;
                tx_next_d  = tx_last_q;
                r_status_d = ST_CLEAR;
              end
            end else begin
              r_status_d = ST_ERROR;
            end
          end

          OP_LOAD: begin
            tx_we = (idx_q < MAX_PDU);
          end

          OP_START: begin
            if (plen_q == 12'd0) begin
              r_status_d = ST_REJECT;
            end else begin
              tx_last_d = now_q;
              r_valid_d = 1'b1;
              r_id_d    = id_q;
              base_d    = '0;
              state_d   = S_TX_RD;
              if (plen_q <= 12'd7) begin
                r_dlc_d       = 4'(plen_q[3:0] + 4'd1);
                r_data_d[7:0] = plen_q[7:0];
                tx_phase_d    = PH_IDLE;
                r_status_d    = ST_DONE;
                n_d           = plen_q[3:0];
                slot_d        = 3'd1;
              end else begin
                tx_len_d       = plen_q;
                tx_ident_d     = id_q;
                tx_seq_d       = SEQ_FIRST;
                tx_pos_d       = 12'd6;
                tx_bs_d        = '0;
                tx_rem_d       = '0;
                tx_sep_d       = '0;
                tx_phase_d     = PH_WAIT;
                tx_wait_d      = now_q;
                r_dlc_d        = 4'd8;
                r_data_d[7:0]  = FF_MARK | {4'd0, plen_q[11:8]};
                r_data_d[15:8] = plen_q[7:0];
                r_status_d     = ST_NEEDFC;
                n_d            = 4'd6;
                slot_d         = 3'd2;
              end
            end
          end

          OP_POLL: begin
            tx_last_d = now_q;
            state_d   = S_TMO;
            if (tx_phase_q == PH_SEND) begin
              if (tx_pos_q >= tx_len_q) begin
                tx_phase_d = PH_IDLE;
              end else if (alu_rsp.carry) begin
                // now at or past the separation deadline
                if (tx_bs_q != 8'd0 && tx_rem_q == 8'd0) begin
                  tx_phase_d = PH_WAIT;
                  tx_wait_d  = now_q;
                  r_status_d = ST_NEEDFC;
                end else begin
                  r_valid_d     = 1'b1;
                  r_id_d        = tx_ident_q;
                  r_dlc_d       = 4'd8;
                  r_data_d[7:0] = tx_seq_q;
                  n_d           = tx_chunk;
                  base_d        = tx_pos_q;
                  slot_d        = 3'd1;
                  tx_pos_d      = tx_pos_q + {8'd0, tx_chunk};
                  tx_seq_d      = next_seq(tx_seq_q);
                  if (tx_bs_q != 8'd0 && tx_rem_q != 8'd0) begin
                    tx_rem_d = tx_rem_q - 8'd1;
                  end
                  state_d = S_POLL_ADD;
                end
              end
            end
          end

          OP_READ: begin
            if (idx_q < rx_cnt_q) begin
              state_d = S_RD_WAIT;
            end
          end

          default: begin
            state_d = S_FINISH;
          end
        endcase
      end

      S_RX_WR: begin
        rx_we  = 1'b1;
        data_d = data_q >> 8;
        cnt_d  = cnt_q + 4'd1;
        if (cnt_q + 4'd1 == n_q) begin
          state_d = S_FINISH;
        end
      end

      S_POLL_ADD: begin
        alu_req.b   = {47'd0, tx_sep_q};
        alu_req.sub = 1'b0;
        tx_next_d   = alu_rsp.sum;
        if (tx_pos_q >= tx_len_q) begin
          tx_phase_d = PH_IDLE;
          r_status_d = ST_DONE;
        end else begin
          r_status_d = ST_CONT;
        end
        state_d = S_TX_RD;
      end

      // tx store reads are registered, so the first step only issues a read
      S_TX_RD: begin
        if (cnt_q != 4'd0) begin
          r_data_d[8*slot_sel +: 8] = tx_rdata_q;
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == n_q) begin
          state_d = S_TMO;
        end
      end

      S_TMO: begin
        alu_req.b = tx_wait_q;
        if (op_q == OP_POLL && tx_phase_q == PH_WAIT &&
            (alu_rsp.sum[63:32] != 32'd0 || alu_rsp.sum[31:0] > flow_timeout_i)) begin
          r_tmo_d = 1'b1;
        end
        state_d = S_FINISH;
      end

      S_RD_WAIT: begin
        r_rbyte_d = rx_rdata_q;
        state_d   = S_FINISH;
      end

      S_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rx_exp_q   <= '0;
      rx_cnt_q   <= '0;
      rx_seq_q   <= SEQ_FIRST;
      rx_multi_q <= 1'b0;
      tx_len_q   <= '0;
      tx_pos_q   <= '0;
      tx_ident_q <= '0;
      tx_seq_q   <= SEQ_FIRST;
      tx_bs_q    <= '0;
      tx_rem_q   <= '0;
      tx_sep_q   <= '0;
      tx_phase_q <= PH_IDLE;
      tx_next_q  <= '0;
      tx_wait_q  <= '0;
      tx_last_q  <= '0;
      cnt_q      <= '0;
      n_q        <= '0;
    end else begin
      state_q    <= state_d;
      rx_exp_q   <= rx_exp_d;
      rx_cnt_q   <= rx_cnt_d;
      rx_seq_q   <= rx_seq_d;
      rx_multi_q <= rx_multi_d;
      tx_len_q   <= tx_len_d;
      tx_pos_q   <= tx_pos_d;
      tx_ident_q <= tx_ident_d;
      tx_seq_q   <= tx_seq_d;
      tx_bs_q    <= tx_bs_d;
      tx_rem_q   <= tx_rem_d;
      tx_sep_q   <= tx_sep_d;
      tx_phase_q <= tx_phase_d;
      tx_next_q  <= tx_next_d;
      tx_wait_q  <= tx_wait_d;
      tx_last_q  <= tx_last_d;
      cnt_q      <= cnt_d;
      n_q        <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    id_q       <= id_d;
    dlc_q      <= dlc_d;
    data_q     <= data_d;
    now_q      <= now_d;
    plen_q     <= plen_d;
    idx_q      <= idx_d;
    tbyte_q    <= tbyte_d;
    base_q     <= base_d;
    slot_q     <= slot_d;
    r_status_q <= r_status_d;
    r_valid_q  <= r_valid_d;
    r_id_q     <= r_id_d;
    r_dlc_q    <= r_dlc_d;
    r_data_q   <= r_data_d;
    r_tmo_q    <= r_tmo_d;
    r_rbyte_q  <= r_rbyte_d;
  end

  assign res_o.status          = r_status_q;
  assign res_o.frame_valid     = r_valid_q;
  assign res_o.out_id          = r_id_q;
  assign res_o.out_dlc         = r_dlc_q;
  assign res_o.out_data        = r_data_q;
  assign res_o.timed_out       = r_tmo_q;
  assign res_o.received_length = rx_exp_q;
  assign res_o.read_byte       = r_rbyte_q;

endmodule

// ----- design/isotp_transport_engine.sv -----
// ISO-TP transport engine: one beat in, one beat out; a new beat is taken only after
// the last result has gone to the output register. Receive frames: decode, one rx store
// write per payload byte, finish. Start: decode, then finish if rejected, else one tx
// store read per byte, timeout check, finish. Poll: decode, with a frame a deadline add
// on the shared adder and one tx store read per byte, then timeout check and finish.
// Reset (async, active low) clears protocol state, reloads the timeout; stores kept.
module isotp_transport_engine (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // can_id, frame_dlc, frame_data, now_us, pdu_length, buffer_index, tx_byte
  input  logic [183:0] s_axis_tdata,
  // opcode
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, out_id, out_dlc, out_data, timed_out, received_length, read_byte
  output logic [111:0] m_axis_tdata,
  // frame_valid
  output logic [0:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_data_i
);
  import isotp_pkg::*;

  logic [31:0]  flow_timeout_q;
  item_t        item;
  res_t         res;
  logic         res_valid, res_ready;
  logic         out_valid_q;
  logic [111:0] out_data_q;
  logic         out_user_q;

  assign item.opcode       = s_axis_tuser;
  assign item.can_id       = s_axis_tdata[15:0];
  assign item.frame_dlc    = s_axis_tdata[19:16];
  assign item.frame_data   = s_axis_tdata[83:20];
  assign item.now_us       = s_axis_tdata[147:84];
  assign item.pdu_length   = s_axis_tdata[159:148];
  assign item.buffer_index = s_axis_tdata[171:160];
  assign item.tx_byte      = s_axis_tdata[179:172];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_timeout_q <= FLOW_TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      flow_timeout_q <= cfg_data_i;
    end
  end

  isotp_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .item_i         (item),
    .flow_timeout_i (flow_timeout_q),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  // output register decouples the engine from the sink
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= {3'd0, res.read_byte, res.received_length, res.timed_out,
                     res.out_data, res.out_dlc, res.out_id, res.status};
      out_user_q <= res.frame_valid;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_user_q;

endmodule

// ----- design/isotp_checker.sv -----
// Port-level checks of the ISO-TP engine, bound to the top level
`include "isotp_transport_engine_assert.svh"

module isotp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser
);

  `ISOTP_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  `ISOTP_ASSERT_ALWAYS(a_rst_no_beat, clk_i, !rst_ni |=> !m_axis_tvalid)
  `ISOTP_ASSERT(a_noframe_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[87:4] == 84'd0)
  `ISOTP_ASSERT(a_status_range, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd8)
  `ISOTP_ASSERT(a_frame_dlc, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[23:20] != 4'd0 && m_axis_tdata[23:20] <= 4'd8)

endmodule

bind isotp_transport_engine isotp_checker u_checker (.*);
